// ===== sv/i2cbw_pkg.sv =====
package i2cbw_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 4;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [CNT_W-1:0] START_LAST = 4'd3;
  localparam logic [CNT_W-1:0] STOP_LAST  = 4'd7;
  localparam logic [CNT_W-1:0] BIT_LAST   = 4'd7;
  localparam logic [CNT_W-1:0] ACK_LAST   = 4'd9;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_STOP  = 5'b00100,
    ST_DATA  = 5'b01000,
    ST_ACK   = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    PH_SET  = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_t;

endpackage

// ===== sv/i2cbw_shift.sv =====
module i2cbw_shift
  import i2cbw_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic              shift,
  input  logic [BYTE_W-1:0] din,
  output logic              msb
);

  logic [BYTE_W-1:0] shift_reg;

  always_ff @(posedge clk) begin
    if (load) begin
      shift_reg <= din;
    end else if (shift) begin
      shift_reg <= {shift_reg[BYTE_W-2:0], 1'b0};
    end
  end

  assign msb = shift_reg[BYTE_W-1];

endmodule

// ===== sv/i2c_bitbang_write_master.sv =====
// An accepted operation moves the sequencer out of idle; each line slot it then makes is
// registered into the output when that is empty or being read, one slot per cycle while
// out_ready stays high. No new operation is accepted until its last slot is emitted.
// An unused operation code is accepted and produces nothing.
// Reset: the internal SDA and SCL states go high, the sequencer returns to idle, the output is empty.
module i2c_bitbang_write_master
  import i2cbw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        operation,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              sda_level,
  output logic              scl_level,
  output logic              last_slot
);

  state_t           state, state_next;
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             sda, scl;
  logic             sda_slot, scl_slot, last;
  logic             emit, accept, load, shift, msb;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (state != ST_IDLE) && (!out_valid || out_ready);
  assign load     = accept && (operation == OP_WRITE);
  assign shift    = emit && (state == ST_DATA) && (phase == PH_SET);

  i2cbw_shift u_shift (
    .clk   (clk),
    .load  (load),
    .shift (shift),
    .din   (data_byte),
    .msb   (msb)
  );

  always_comb begin
    sda_slot   = sda;
    scl_slot   = scl;
    last       = 1'b0;
    state_next = state;
    phase_next = phase;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next   = '0;
        phase_next = PH_SET;
        if (accept) begin
          case (operation)
            OP_START: state_next = ST_START;
            OP_STOP:  state_next = ST_STOP;
            OP_WRITE: state_next = ST_DATA;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_START: begin
        sda_slot = (cnt < 4'd2);
        scl_slot = (cnt == '0) ? scl : (cnt != START_LAST);
        last     = (cnt == START_LAST);
        if (emit) begin
          cnt_next   = cnt + 1'b1;
          state_next = last ? ST_IDLE : ST_START;
        end
      end
      ST_STOP: begin
        sda_slot = (cnt >= 4'd2);
        scl_slot = (cnt == '0) ? scl : 1'b1;
        last     = (cnt == STOP_LAST);
        if (emit) begin
          cnt_next   = cnt + 1'b1;
          state_next = last ? ST_IDLE : ST_STOP;
        end
      end
      ST_DATA: begin
        case (phase)
          PH_SET: begin
            sda_slot = msb;
            if (emit) phase_next = PH_HIGH;
          end
          PH_HIGH: begin
            scl_slot = 1'b1;
            if (emit) phase_next = PH_LOW;
          end
          PH_LOW: begin
            scl_slot = 1'b0;
            if (emit) begin
              phase_next = PH_SET;
              if (cnt == BIT_LAST) begin
                cnt_next   = '0;
                state_next = ST_ACK;
              end else begin
                cnt_next = cnt + 1'b1;
              end
            end
          end
          default: phase_next = PH_SET;
        endcase
      end
      ST_ACK: begin
        sda_slot = 1'b1;
        scl_slot = (cnt == 4'd1);
        last     = (cnt == ACK_LAST);
        if (emit) begin
          cnt_next   = cnt + 1'b1;
          state_next = last ? ST_IDLE : ST_ACK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_SET;
      cnt       <= '0;
      sda       <= 1'b1;
      scl       <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      cnt   <= cnt_next;
      if (emit) begin
        sda       <= sda_slot;
        scl       <= scl_slot;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sda_level <= sda_slot;
      scl_level <= scl_slot;
      last_slot <= last;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst)
    (emit && last) |=> (state == ST_IDLE && out_valid && last_slot))
    else $error("last slot did not return sequencer to idle");

  assert property (@(posedge clk) disable iff (rst)
    (emit && state == ST_START && cnt == START_LAST) |=> (!sda && !scl))
    else $error("start condition left lines in wrong state");

  assert property (@(posedge clk) disable iff (rst)
    (emit && state == ST_ACK && cnt == ACK_LAST) |=> (sda && !scl))
    else $error("write left lines in wrong state");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACK) |-> (cnt <= ACK_LAST && phase == PH_SET))
    else $error("acknowledge counter out of range");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(sda_level) && $stable(scl_level) && $stable(last_slot)))
    else $error("stalled slot overwritten");
`endif

endmodule

// ===== bench/i2c_bitbang_write_master_test.sv =====
`timescale 1ns / 100ps

module i2c_bitbang_write_master_test;
  import i2cbw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_OPS = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned HOLD_OFF_AFTER = 1000;

  class line_slot_scoreboard;
    typedef struct packed {
      logic sda;
      logic scl;
      logic last;
    } line_slot_t;

    line_slot_t expected_slots[$];
    logic sda_now;
    logic scl_now;
    int errors;
    int checked;

    function new();
      sda_now = 1'b1;
      scl_now = 1'b1;
      errors = 0;
      checked = 0;
    endfunction

    function void add_slot(logic sda, logic scl, logic last);
      line_slot_t s;
      sda_now = sda;
      scl_now = scl;
      s.sda = sda;
      s.scl = scl;
      s.last = last;
      expected_slots.push_back(s);
    endfunction

    function void note_transaction(logic [1:0] op, logic [BYTE_W-1:0] data);
      case (op)
        OP_START: begin
          add_slot(1'b1, scl_now, 1'b0);
          add_slot(1'b1, 1'b1, 1'b0);
          add_slot(1'b0, 1'b1, 1'b0);
          add_slot(1'b0, 1'b0, 1'b1);
        end
        OP_STOP: begin
          add_slot(1'b0, scl_now, 1'b0);
          add_slot(1'b0, 1'b1, 1'b0);
          for (int i = 0; i < 6; i++) add_slot(1'b1, 1'b1, i == 5);
        end
        OP_WRITE: begin
          for (int b = BYTE_W - 1; b >= 0; b--) begin
            add_slot(data[b], scl_now, 1'b0);
            add_slot(data[b], 1'b1, 1'b0);
            add_slot(data[b], 1'b0, 1'b0);
          end
          add_slot(1'b1, 1'b0, 1'b0);
          add_slot(1'b1, 1'b1, 1'b0);
          add_slot(1'b1, 1'b0, 1'b0);
          for (int i = 0; i < 7; i++) add_slot(1'b1, 1'b0, i == 6);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_slot(logic sda, logic scl, logic last);
      line_slot_t s;
      checked++;
      if (expected_slots.size() == 0) begin
        $error("unexpected line slot: sda_level %0b scl_level %0b last_slot %0b",
               sda, scl, last);
        errors++;
        return;
      end
      s = expected_slots.pop_front();
      if (sda !== s.sda) begin
        $error("sda_level: expected %0b, got %0b", s.sda, sda);
        errors++;
      end
      if (scl !== s.scl) begin
        $error("scl_level: expected %0b, got %0b", s.scl, scl);
        errors++;
      end
      if (last !== s.last) begin
        $error("last_slot: expected %0b, got %0b", s.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [1:0] operation;
  logic [BYTE_W-1:0] data_byte;
  logic out_valid;
  logic out_ready;
  logic sda_level;
  logic scl_level;
  logic last_slot;

  line_slot_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int ops_sent;

  i2c_bitbang_write_master dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sda_level (sda_level),
    .scl_level (scl_level),
    .last_slot (last_slot)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("i2c_bitbang_write_master_test: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_transaction(operation, data_byte);
      if (out_valid && out_ready) sb.check_slot(sda_level, scl_level, last_slot);
    end
  end

  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sb.checked >= HOLD_OFF_AFTER) begin
        held = 1;
        hold = HOLD_OFF_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [BYTE_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    data_byte <= data;
    do @(posedge clk); while (!in_ready);
    if (op != OP_UNUSED) ops_sent++;
  endtask

  task automatic set_idling();
    if (ops_sent < RANDOM_OPS / 3) begin
      send_idle_pct = 25;
      recv_idle_pct = 66;
    end else if (ops_sent < 2 * RANDOM_OPS / 3) begin
      send_idle_pct = 66;
      recv_idle_pct = 25;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  initial begin
    int nwrites;
    sb = new();
    ops_sent = 0;
    send_idle_pct = 25;
    recv_idle_pct = 66;
    rst <= 1'b1;
    in_valid <= 1'b0;
    operation <= OP_START;
    data_byte <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_op(OP_UNUSED, 8'hFF);
    send_op(OP_STOP, 8'h00);
    send_op(OP_START, 8'hFF);
    send_op(OP_START, 8'h00);
    send_op(OP_WRITE, 8'h00);
    send_op(OP_WRITE, 8'hFF);
    send_op(OP_WRITE, 8'h80);
    send_op(OP_WRITE, 8'h01);
    send_op(OP_WRITE, 8'hA5);
    send_op(OP_WRITE, 8'h5A);
    send_op(OP_UNUSED, 8'h00);
    send_op(OP_STOP, 8'hFF);
    send_op(OP_WRITE, 8'h3C);
    send_op(OP_STOP, 8'h00);
    send_op(OP_STOP, 8'h55);
    send_op(OP_START, 8'hAA);
    send_op(OP_WRITE, 8'h7F);
    send_op(OP_WRITE, 8'hFE);
    send_op(OP_STOP, 8'h00);
    ops_sent = 0;

    while (ops_sent < RANDOM_OPS) begin
      set_idling();
      if ($urandom_range(99) < 80) begin
        send_op(OP_START, 8'($urandom));
        nwrites = $urandom_range(1, 4);
        for (int i = 0; i < nwrites; i++) send_op(OP_WRITE, 8'($urandom));
        if ($urandom_range(9) != 0) send_op(OP_STOP, 8'($urandom));
      end else begin
        send_op(2'($urandom_range(3)), 8'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_slots.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_slots.size() == 0) begin
      $display("i2c_bitbang_write_master_test: PASS");
    end else begin
      $display("i2c_bitbang_write_master_test: FAIL");
    end
    $finish;
  end

endmodule
